FILE: hdl/rwt_pkg.sv
package rwt_pkg;

   // field widths of the request and response beats
   localparam int TYPE_W    = 3;
   localparam int LEN_W     = 12;
   localparam int SEQ_IN_W  = 8;
   localparam int SEQ_W     = 7;
   localparam int COUNT_W   = 8;
   localparam int SLOT_W    = 3;
   localparam int STATUS_W  = 3;
   localparam int RETRY_W   = 8;
   localparam int SLOT_SEQ_W = 8;

   // sizing
   localparam int DEF_WINDOW_SLOTS = 8;
   localparam int SEQ_MODULUS      = 128;
   localparam int MAX_FRAME_BYTES  = 2048;

   localparam logic [LEN_W-1:0]      MIN_LEN_RESET = 12'd6;
   localparam logic [SLOT_SEQ_W-1:0] SEQ_EMPTY     = 8'hFF;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_STORE         = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_LOOKUP        = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_CONSUME       = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_CLEAR_ALL     = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_BUMP_RETRY    = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_CLEAN_THROUGH = 3'd5;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NEXT     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;
   localparam logic [STATUS_W-1:0] ST_DONE     = 3'd6;

   // one window slot as kept in the slot ram
   typedef struct packed {
      logic [SLOT_SEQ_W-1:0] seq;
      logic [LEN_W-1:0]      length;
      logic [RETRY_W-1:0]    retries;
   } slot_entry_type;

   localparam slot_entry_type SLOT_RESET = '{seq: SEQ_EMPTY, length: '0, retries: '0};

endpackage

FILE: hdl/rwt_if.sv
interface rwt_req_if;
   import rwt_pkg::*;

   logic                valid;
   logic                ready;
   logic [TYPE_W-1:0]   req_type;
   logic [LEN_W-1:0]    frame_length;
   logic [SEQ_IN_W-1:0] seq_number;
   logic [COUNT_W-1:0]  release_count;
   logic [SLOT_W-1:0]   slot_index;
   logic                include_target;

   modport source (
      output valid, req_type, frame_length, seq_number, release_count, slot_index,
             include_target,
      input  ready
   );

   modport sink (
      input  valid, req_type, frame_length, seq_number, release_count, slot_index,
             include_target,
      output ready
   );
endinterface

interface rwt_rsp_if;
   import rwt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   window_slot;
   logic [SEQ_W-1:0]    seq_assigned;
   logic [SLOT_W-1:0]   filled_level;
   logic [RETRY_W-1:0]  retry_count;
   logic [SLOT_W-1:0]   released;

   modport source (
      output valid, status, window_slot, seq_assigned, filled_level, retry_count, released,
      input  ready
   );

   modport sink (
      input  valid, status, window_slot, seq_assigned, filled_level, retry_count, released,
      output ready
   );
endinterface

FILE: hdl/rwt_ram.sv
module rwt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/retransmit_window_tracker.sv
// Retransmission window tracker: a ring of WINDOW_SLOTS outstanding frames
// (at most WINDOW_SLOTS-1 in use), each with a sequence number, length and
// retry count. Requests arrive as beats on req_ch and each gives exactly one
// response beat on rsp_ch. csr_wr_en/csr_wr_data set the minimum frame length.
// Every request passes a decode state and then a response state; an accepted
// store and a retry bump read their slot in decode and write it back before
// the response, while lookup, clear all and clean through first walk the ring.
// One request is in work at a time; req_ch.ready rises again in the cycle the
// response is registered, and the next request may be taken from then on. The
// sequencer walks the ring one slot per cycle; a lookup reads the slots through
// the single read port of the slot ram.
// Reset empties the window, zeroes the sequence counter and sets every slot
// to its empty value at once through per-slot valid bits; no clearing pass.
// A response that is not taken stays in the output register; the block then
// finishes its next request and waits with it until the register frees up.
module retransmit_window_tracker #(
   parameter int WINDOW_SLOTS = rwt_pkg::DEF_WINDOW_SLOTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [rwt_pkg::LEN_W-1:0] csr_wr_data,
   rwt_req_if.sink                   req_ch,
   rwt_rsp_if.source                 rsp_ch
);
   import rwt_pkg::*;

   localparam int PTR_W   = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int ENTRY_W = $bits(slot_entry_type);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WINDOW_SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_STORE_WR,
      S_BUMP_WR,
      S_SCAN,
      S_WIPE_ALL,
      S_CLEAN,
      S_RESP
   } state_type;

   // ring helpers
   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   function automatic logic [PTR_W-1:0] ring_dist(input logic [PTR_W-1:0] h,
                                                   input logic [PTR_W-1:0] t);
      logic [PTR_W:0] d;
      d = {1'b0, h} - {1'b0, t};
      if (h < t) begin
         d = d + (PTR_W+1)'(WINDOW_SLOTS);
      end
      return d[PTR_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] slot_mod(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      r = s;
      for (int k = 0; k < 4; k++) begin
         if (32'(r) >= WINDOW_SLOTS) begin
            r = r - SLOT_W'(WINDOW_SLOTS);
         end
      end
      return PTR_W'(r);
   endfunction

   state_type                state_ff, state_in;
   logic [PTR_W-1:0]         head_ff, head_in;
   logic [PTR_W-1:0]         tail_ff, tail_in;
   logic [SEQ_W-1:0]         next_seq_ff, next_seq_in;
   logic [WINDOW_SLOTS-1:0]  valid_ff, valid_in;
   logic [LEN_W-1:0]         min_len_ff, min_len_in;

   // latched request
   logic [TYPE_W-1:0]        op_ff, op_in;
   logic [LEN_W-1:0]         flen_ff, flen_in;
   logic [SEQ_W-1:0]         number_ff, number_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [PTR_W-1:0]         idx_ff, idx_in;
   logic                     incl_ff, incl_in;

   // walk control
   logic [PTR_W-1:0]         scan_ptr_ff, scan_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic                     pend_ff, pend_in;

   // working result
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic [PTR_W-1:0]         res_slot_ff, res_slot_in;
   logic [SEQ_W-1:0]         res_seq_ff, res_seq_in;
   logic [RETRY_W-1:0]       res_retry_ff, res_retry_in;
   logic [PTR_W-1:0]         res_rel_ff, res_rel_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [SEQ_W-1:0]         rsp_seq_ff, rsp_seq_in;
   logic [SLOT_W-1:0]        rsp_level_ff, rsp_level_in;
   logic [RETRY_W-1:0]       rsp_retry_ff, rsp_retry_in;
   logic [SLOT_W-1:0]        rsp_rel_ff, rsp_rel_in;

   // slot ram ports
   logic                     ram_wr_en;
   logic [PTR_W-1:0]         ram_wr_addr;
   logic [ENTRY_W-1:0]       ram_wr_data;
   logic                     ram_rd_en;
   logic [PTR_W-1:0]         ram_rd_addr;
   logic [ENTRY_W-1:0]       ram_rd_data;

   logic [PTR_W-1:0]         level;
   slot_entry_type           entry_eff;

   rwt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WINDOW_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // a slot never written since reset or last wipe reads as empty
   assign entry_eff = valid_ff[rd_ptr_ff] ? slot_entry_type'(ram_rd_data) : SLOT_RESET;
   assign level     = ring_dist(head_ff, tail_ff);

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.window_slot  = rsp_slot_ff;
   assign rsp_ch.seq_assigned = rsp_seq_ff;
   assign rsp_ch.filled_level = rsp_level_ff;
   assign rsp_ch.retry_count  = rsp_retry_ff;
   assign rsp_ch.released     = rsp_rel_ff;

   // sequencer
   always_comb begin
      logic [PTR_W:0]         tail_sum;
      logic [PTR_W-1:0]       rel;
      slot_entry_type         wr_entry;
      logic                   next_match;

      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      next_seq_in   = next_seq_ff;
      valid_in      = valid_ff;
      min_len_in    = min_len_ff;
      op_in         = op_ff;
      flen_in       = flen_ff;
      number_in     = number_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      incl_in       = incl_ff;
      scan_ptr_in   = scan_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      pend_in       = pend_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_seq_in    = res_seq_ff;
      res_retry_in  = res_retry_ff;
      res_rel_in    = res_rel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_retry_in  = rsp_retry_ff;
      rsp_rel_in    = rsp_rel_ff;

      ram_rd_en   = 1'b0;
      ram_rd_addr = scan_ptr_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = rd_ptr_ff;
      wr_entry    = entry_eff;
      tail_sum    = '0;
      rel         = '0;
      next_match  = ((9'(entry_eff.seq) + 9'd1) == 9'(number_ff)) ||
                    (9'(entry_eff.seq) == (9'(number_ff) + 9'(SEQ_MODULUS - 1)));

      // configuration write
      if (csr_wr_en) begin
         min_len_in = csr_wr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in     = req_ch.req_type;
               flen_in   = req_ch.frame_length;
               number_in = req_ch.seq_number[SEQ_W-1:0];
               count_in  = req_ch.release_count;
               idx_in    = slot_mod(req_ch.slot_index);
               incl_in   = req_ch.include_target;
               state_in  = S_DECODE;
            end
         end

         S_DECODE: begin
            res_status_in = ST_DONE;
            res_slot_in   = '0;
            res_seq_in    = '0;
            res_retry_in  = '0;
            res_rel_in    = '0;
            state_in      = S_RESP;
            unique case (op_ff)
               REQ_STORE: begin
                  if ((flen_ff < min_len_ff) || (32'(flen_ff) > MAX_FRAME_BYTES)) begin
                     res_status_in = ST_SHORT;
                  end else if (level >= LAST_SLOT) begin
                     res_status_in = ST_FULL;
                  end else begin
                     // fetch the head slot to keep its retry count
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = head_ff;
                     rd_ptr_in   = head_ff;
                     state_in    = S_STORE_WR;
                  end
               end
               REQ_LOOKUP: begin
                  res_status_in = ST_NOTFOUND;
                  if (head_ff != tail_ff) begin
                     scan_ptr_in = tail_ff;
                     pend_in     = 1'b0;
                     state_in    = S_SCAN;
                  end
               end
               REQ_CONSUME: begin
                  rel        = (count_ff < COUNT_W'(level)) ? PTR_W'(count_ff) : level;
                  tail_sum   = {1'b0, tail_ff} + {1'b0, rel};
                  if (tail_sum >= (PTR_W+1)'(WINDOW_SLOTS)) begin
                     tail_sum = tail_sum - (PTR_W+1)'(WINDOW_SLOTS);
                  end
                  tail_in    = tail_sum[PTR_W-1:0];
                  res_rel_in = rel;
               end
               REQ_CLEAR_ALL: begin
                  scan_ptr_in = tail_ff;
                  state_in    = S_WIPE_ALL;
               end
               REQ_BUMP_RETRY: begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_ff;
                  rd_ptr_in   = idx_ff;
                  state_in    = S_BUMP_WR;
               end
               REQ_CLEAN_THROUGH: begin
                  scan_ptr_in = tail_ff;
                  state_in    = S_CLEAN;
               end
               default: begin
                  res_status_in = ST_DONE;
               end
            endcase
         end

         // write the new frame into the head slot
         S_STORE_WR: begin
            wr_entry.seq    = {1'b0, next_seq_ff};
            wr_entry.length = flen_ff;
            ram_wr_en       = 1'b1;
            valid_in[rd_ptr_ff] = 1'b1;
            res_status_in   = ST_STORED;
            res_slot_in     = head_ff;
            res_seq_in      = next_seq_ff;
            next_seq_in     = (next_seq_ff == SEQ_W'(SEQ_MODULUS - 1)) ? '0
                                                                   : SEQ_W'(next_seq_ff + 1'b1);
            head_in         = ring_next(head_ff);
            state_in        = S_RESP;
         end

         // increment the addressed slot's retry count
         S_BUMP_WR: begin
            wr_entry.retries = RETRY_W'(entry_eff.retries + 1'b1);
            ram_wr_en        = 1'b1;
            valid_in[rd_ptr_ff] = 1'b1;
            res_retry_in     = wr_entry.retries;
            state_in         = S_RESP;
         end

         // read one slot per cycle, compare the one read last cycle
         S_SCAN: begin
            if (pend_ff && (entry_eff.seq == {1'b0, number_ff})) begin
               res_status_in = ST_FOUND;
               res_slot_in   = rd_ptr_ff;
               state_in      = S_RESP;
            end else if (scan_ptr_ff != head_ff) begin
               ram_rd_en   = 1'b1;
               rd_ptr_in   = scan_ptr_ff;
               scan_ptr_in = ring_next(scan_ptr_ff);
               pend_in     = 1'b1;
            end else begin
               // last compared slot is the newest one
               res_status_in = next_match ? ST_NEXT : ST_NOTFOUND;
               state_in      = S_RESP;
            end
         end

         // wipe tail up to head, then empty the ring
         S_WIPE_ALL: begin
            if (scan_ptr_ff != head_ff) begin
               valid_in[scan_ptr_ff] = 1'b0;
               scan_ptr_in = ring_next(scan_ptr_ff);
            end else begin
               head_in  = '0;
               tail_in  = '0;
               state_in = S_RESP;
            end
         end

         // wipe tail up to the addressed slot, and that slot too if include_target is set
         S_CLEAN: begin
            if (scan_ptr_ff != idx_ff) begin
               valid_in[scan_ptr_ff] = 1'b0;
               scan_ptr_in = ring_next(scan_ptr_ff);
            end else begin
               if (incl_ff) begin
                  valid_in[idx_ff] = 1'b0;
               end
               state_in = S_RESP;
            end
         end

         // hand the result to the output register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = SLOT_W'(res_slot_ff);
               rsp_seq_in    = res_seq_ff;
               rsp_level_in  = SLOT_W'(level);
               rsp_retry_in  = res_retry_ff;
               rsp_rel_in    = SLOT_W'(res_rel_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      ram_wr_data = wr_entry;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         next_seq_ff  <= '0;
         valid_ff     <= '0;
         min_len_ff   <= MIN_LEN_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         next_seq_ff  <= next_seq_in;
         valid_ff     <= valid_in;
         min_len_ff   <= min_len_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      flen_ff       <= flen_in;
      number_ff     <= number_in;
      count_ff      <= count_in;
      idx_ff        <= idx_in;
      incl_ff       <= incl_in;
      scan_ptr_ff   <= scan_ptr_in;
      rd_ptr_ff     <= rd_ptr_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_seq_ff    <= res_seq_in;
      res_retry_ff  <= res_retry_in;
      res_rel_ff    <= res_rel_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_retry_ff  <= rsp_retry_in;
      rsp_rel_ff    <= rsp_rel_in;
   end

endmodule

FILE: hdl/rwt_checker.sv
module rwt_checker #(
   parameter int WINDOW_SLOTS = rwt_pkg::DEF_WINDOW_SLOTS
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic [rwt_pkg::STATUS_W-1:0] rsp_status,
   input logic [rwt_pkg::SLOT_W-1:0]   rsp_window_slot,
   input logic [rwt_pkg::SEQ_W-1:0]    rsp_seq_assigned,
   input logic [rwt_pkg::SLOT_W-1:0]   rsp_filled_level,
   input logic [rwt_pkg::RETRY_W-1:0]  rsp_retry_count,
   input logic [rwt_pkg::SLOT_W-1:0]   rsp_released
);
   import rwt_pkg::*;

   // one request in work at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

   // a full window holds exactly one slot less than the ring
   a_full_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_filled_level == SLOT_W'(WINDOW_SLOTS - 1))
      else $error("full status with wrong level");

   // slot and sequence fields only on store and found
   a_slot_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_STORED) && (rsp_status != ST_FOUND)
      |-> (rsp_window_slot == '0) && (rsp_seq_assigned == '0))
      else $error("slot fields set on a status that has none");

   // retry and release fields only on done
   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DONE) |-> (rsp_retry_count == '0) && (rsp_released == '0))
      else $error("retry or release field set on a status that has none");

   // reset leaves an idle block with nothing to deliver
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind retransmit_window_tracker rwt_checker #(
   .WINDOW_SLOTS (WINDOW_SLOTS)
) u_rwt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_status       (rsp_ch.status),
   .rsp_window_slot  (rsp_ch.window_slot),
   .rsp_seq_assigned (rsp_ch.seq_assigned),
   .rsp_filled_level (rsp_ch.filled_level),
   .rsp_retry_count  (rsp_ch.retry_count),
   .rsp_released     (rsp_ch.released)
);

FILE: tb/sv/tb_retransmit_window_tracker.sv
module tb_retransmit_window_tracker;
   import rwt_pkg::*;

   localparam int SLOTS            = DEF_WINDOW_SLOTS;
   localparam int RUN_LIMIT        = 400000;
   localparam int ITEMS_PER_PHASE  = 220;
   localparam int PHASE_COUNT      = 6;
   localparam int HOLDOFF_CYCLES   = 300;
   localparam int BUMP_BURST       = 260;
   localparam int SETTLE_CYCLES    = 2 * SLOTS + 8;

   // request codes the block must treat as no-ops
   localparam logic [TYPE_W-1:0] REQ_RESERVED_A = 3'd6;
   localparam logic [TYPE_W-1:0] REQ_RESERVED_B = 3'd7;

   typedef struct {
      logic [TYPE_W-1:0]   kind;
      logic [LEN_W-1:0]    frame_length;
      logic [SEQ_IN_W-1:0] seq_number;
      logic [COUNT_W-1:0]  release_count;
      logic [SLOT_W-1:0]   slot_index;
      logic                include_target;
   } window_req_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   window_slot;
      logic [SEQ_W-1:0]    seq_assigned;
      logic [SLOT_W-1:0]   filled_level;
      logic [RETRY_W-1:0]  retry_count;
      logic [SLOT_W-1:0]   released;
   } window_rsp_type;

   typedef struct {
      window_req_type beat;
      bit             typed;
      window_rsp_type want;
   } opening_row_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [LEN_W-1:0]    csr_wr_data;

   rwt_req_if req_ch ();
   rwt_rsp_if rsp_ch ();

   retransmit_window_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // shadow copy of the window
   logic [LEN_W-1:0]      w_min_len;
   logic [SLOT_W-1:0]     w_head;
   logic [SLOT_W-1:0]     w_tail;
   logic [SEQ_W-1:0]      w_next_seq;
   logic [SLOT_SEQ_W-1:0] w_seq     [SLOTS];
   logic [LEN_W-1:0]      w_len     [SLOTS];
   logic [RETRY_W-1:0]    w_retries [SLOTS];

   window_rsp_type  replies_due [$];
   opening_row_type opening_rows [$];

   int          mismatches;
   int unsigned cycle_count;
   int          send_idle_pct;
   int          rsp_stall_pct;
   int          holdoff_asks;
   int          holdoff_seen;
   int          hold_left;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int ring_step(int p);
      return (p + 1) % SLOTS;
   endfunction

   function automatic int window_level();
      return (int'(w_head) + SLOTS - int'(w_tail)) % SLOTS;
   endfunction

   function automatic void blank_slot(int s);
      w_seq[s]     = SEQ_EMPTY;
      w_len[s]     = '0;
      w_retries[s] = '0;
   endfunction

   // apply one request to the shadow window and return the response it earns
   function automatic window_rsp_type advance_window(window_req_type r);
      window_rsp_type   o;
      int               j;
      int               lvl;
      int               rel;
      int               sn;
      int               nm;
      bit               hit;
      logic [SEQ_W-1:0] number;
      o        = '{default: '0};
      o.status = ST_DONE;
      number   = r.seq_number[SEQ_W-1:0];
      hit      = 1'b0;
      case (r.kind)
         REQ_STORE: begin
            if (r.frame_length < w_min_len || r.frame_length > MAX_FRAME_BYTES) begin
               o.status = ST_SHORT;
            end else if (window_level() >= SLOTS - 1) begin
               o.status = ST_FULL;
            end else begin
               o.seq_assigned = w_next_seq;
               w_next_seq     = w_next_seq + 1'b1;
               w_seq[w_head]  = {1'b0, o.seq_assigned};
               w_len[w_head]  = r.frame_length;
               o.window_slot  = w_head;
               w_head         = SLOT_W'(ring_step(int'(w_head)));
               o.status       = ST_STORED;
            end
         end
         REQ_LOOKUP: begin
            o.status = ST_NOTFOUND;
            if (w_head != w_tail) begin
               j = int'(w_tail);
               while (j != int'(w_head) && !hit) begin
                  if (w_seq[j] == {1'b0, number}) begin
                     hit           = 1'b1;
                     o.window_slot = SLOT_W'(j);
                  end else begin
                     j = ring_step(j);
                  end
               end
               if (hit) begin
                  o.status = ST_FOUND;
               end else begin
                  // newest slot sits just behind the head
                  sn = int'(w_seq[(int'(w_head) + SLOTS - 1) % SLOTS]);
                  nm = int'(number);
                  if (nm - sn == 1 || sn - nm == SEQ_MODULUS - 1)
                     o.status = ST_NEXT;
               end
            end
         end
         REQ_CONSUME: begin
            lvl        = window_level();
            rel        = (int'(r.release_count) < lvl) ? int'(r.release_count) : lvl;
            o.released = SLOT_W'(rel);
            w_tail     = SLOT_W'((int'(w_tail) + rel) % SLOTS);
         end
         REQ_CLEAR_ALL: begin
            j = int'(w_tail);
            while (j != int'(w_head)) begin
               blank_slot(j);
               j = ring_step(j);
            end
            w_head = '0;
            w_tail = '0;
         end
         REQ_BUMP_RETRY: begin
            w_retries[r.slot_index] = w_retries[r.slot_index] + 1'b1;
            o.retry_count           = w_retries[r.slot_index];
         end
         REQ_CLEAN_THROUGH: begin
            j = int'(w_tail);
            while (j != int'(r.slot_index)) begin
               blank_slot(j);
               j = ring_step(j);
            end
            if (r.include_target)
               blank_slot(int'(r.slot_index));
         end
         default: begin
         end
      endcase
      o.filled_level = SLOT_W'(window_level());
      return o;
   endfunction

   function automatic void add_row(logic [TYPE_W-1:0] kind, int len, int seq, int cnt,
                                   int slot, bit incl, bit typed = 1'b0,
                                   logic [STATUS_W-1:0] st = ST_DONE, int ws = 0,
                                   int sa = 0, int lvl = 0, int rt = 0, int rl = 0);
      opening_row_type row;
      row.beat.kind           = kind;
      row.beat.frame_length   = LEN_W'(len);
      row.beat.seq_number     = SEQ_IN_W'(seq);
      row.beat.release_count  = COUNT_W'(cnt);
      row.beat.slot_index     = SLOT_W'(slot);
      row.beat.include_target = incl;
      row.typed               = typed;
      row.want.status         = st;
      row.want.window_slot    = SLOT_W'(ws);
      row.want.seq_assigned   = SEQ_W'(sa);
      row.want.filled_level   = SLOT_W'(lvl);
      row.want.retry_count    = RETRY_W'(rt);
      row.want.released       = SLOT_W'(rl);
      opening_rows.push_back(row);
   endfunction

   // random request shaped by where the window stands right now
   function automatic window_req_type next_random_request();
      window_req_type r;
      int             roll;
      int             pick;
      int             lvl;
      int             slot;
      lvl              = window_level();
      r.frame_length   = LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
      r.seq_number     = SEQ_IN_W'($urandom_range(0, (1 << SEQ_IN_W) - 1));
      r.release_count  = COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1));
      r.slot_index     = SLOT_W'($urandom_range(0, SLOTS - 1));
      r.include_target = 1'($urandom_range(0, 1));
      roll             = $urandom_range(0, 99);
      pick             = $urandom_range(0, 99);
      if (roll < 38) begin
         r.kind = REQ_STORE;
         if (pick < 70 && w_min_len <= MAX_FRAME_BYTES)
            r.frame_length = LEN_W'($urandom_range(int'(w_min_len), MAX_FRAME_BYTES));
         else if (pick < 80 && w_min_len > 0)
            r.frame_length = w_min_len - 1'b1;
         else if (pick < 88)
            r.frame_length = w_min_len;
         else if (pick < 94)
            r.frame_length = LEN_W'($urandom_range(MAX_FRAME_BYTES + 1, (1 << LEN_W) - 1));
      end else if (roll < 62) begin
         r.kind = REQ_LOOKUP;
         if (lvl > 0 && pick < 50) begin
            slot         = (int'(w_tail) + $urandom_range(0, lvl - 1)) % SLOTS;
            r.seq_number = {1'($urandom_range(0, 1)), w_seq[slot][SEQ_W-1:0]};
         end else if (lvl > 0 && pick < 70) begin
            slot         = (int'(w_head) + SLOTS - 1) % SLOTS;
            r.seq_number = {1'($urandom_range(0, 1)), 7'(w_seq[slot][SEQ_W-1:0] + 1'b1)};
         end
      end else if (roll < 72) begin
         r.kind = REQ_CONSUME;
         if (pick < 75)
            r.release_count = COUNT_W'($urandom_range(0, 3));
      end else if (roll < 76) begin
         r.kind = REQ_CLEAR_ALL;
      end else if (roll < 86) begin
         r.kind = REQ_BUMP_RETRY;
      end else if (roll < 95) begin
         r.kind = REQ_CLEAN_THROUGH;
         if (pick < 30)
            r.slot_index = w_tail;
      end else begin
         r.kind = (pick < 50) ? REQ_RESERVED_A : REQ_RESERVED_B;
      end
      return r;
   endfunction

   task automatic flag_mismatch(string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatches++;
   endtask

   // offer one request beat and log its expected response once taken
   task automatic offer_request(window_req_type r, bit typed, window_rsp_type want);
      window_rsp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.req_type       <= r.kind;
      req_ch.frame_length   <= r.frame_length;
      req_ch.seq_number     <= r.seq_number;
      req_ch.release_count  <= r.release_count;
      req_ch.slot_index     <= r.slot_index;
      req_ch.include_target <= r.include_target;
      do @(posedge clock); while (!req_ch.ready);
      predicted = advance_window(r);
      replies_due.push_back(typed ? want : predicted);
   endtask

   task automatic drain_replies();
      req_ch.valid <= 1'b0;
      while (replies_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_min_len(logic [LEN_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      w_min_len    = value;
      @(posedge clock);
   endtask

   // response side: random stalls plus one long hold-off, asked for in phase 2
   initial begin
      rsp_ch.ready = 1'b0;
      holdoff_seen = 0;
      hold_left    = 0;
      forever begin
         @(posedge clock);
         if (holdoff_asks != holdoff_seen) begin
            holdoff_seen = holdoff_asks;
            hold_left    = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // compare each response beat against the oldest outstanding expectation
   always @(posedge clock) begin : check_replies
      window_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (replies_due.size() == 0) begin
            flag_mismatch("response beat with no request outstanding");
         end else begin
            want = replies_due.pop_front();
            if (rsp_ch.status !== want.status)
               flag_mismatch($sformatf("status %0d, want %0d", rsp_ch.status, want.status));
            if (rsp_ch.window_slot !== want.window_slot)
               flag_mismatch($sformatf("window_slot %0d, want %0d",
                                       rsp_ch.window_slot, want.window_slot));
            if (rsp_ch.seq_assigned !== want.seq_assigned)
               flag_mismatch($sformatf("seq_assigned %0d, want %0d",
                                       rsp_ch.seq_assigned, want.seq_assigned));
            if (rsp_ch.filled_level !== want.filled_level)
               flag_mismatch($sformatf("filled_level %0d, want %0d",
                                       rsp_ch.filled_level, want.filled_level));
            if (rsp_ch.retry_count !== want.retry_count)
               flag_mismatch($sformatf("retry_count %0d, want %0d",
                                       rsp_ch.retry_count, want.retry_count));
            if (rsp_ch.released !== want.released)
               flag_mismatch($sformatf("released %0d, want %0d",
                                       rsp_ch.released, want.released));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("tb_retransmit_window_tracker: errors");
         $finish;
      end
   end

   initial begin
      window_req_type r;
      window_rsp_type none;
      int             burst_slot;

      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_ch.valid          = 1'b0;
      req_ch.req_type       = '0;
      req_ch.frame_length   = '0;
      req_ch.seq_number     = '0;
      req_ch.release_count  = '0;
      req_ch.slot_index     = '0;
      req_ch.include_target = 1'b0;
      mismatches            = 0;
      cycle_count           = 0;
      send_idle_pct         = 0;
      rsp_stall_pct         = 0;
      holdoff_asks          = 0;
      none                  = '{default: '0};

      // shadow state after reset
      w_min_len  = MIN_LEN_RESET;
      w_head     = '0;
      w_tail     = '0;
      w_next_seq = '0;
      for (int s = 0; s < SLOTS; s++)
         blank_slot(s);

      // opening table: empty lookup, short and oversize frames, fill to full,
      // lookups hit/next/miss, bumps in and out of the window, consume,
      // clean through past and at the tail, reserved codes, clipped consume, clear all
      add_row(REQ_LOOKUP,        0, 8'h00, 0, 0, 0, 1'b1, ST_NOTFOUND);
      add_row(REQ_STORE,         5, 8'h00, 0, 0, 0, 1'b1, ST_SHORT);
      add_row(REQ_STORE,         MAX_FRAME_BYTES + 1, 8'h00, 0, 0, 0, 1'b1, ST_SHORT);
      add_row(REQ_STORE,         6, 8'h00, 0, 0, 0, 1'b1, ST_STORED, 0, 0, 1);
      add_row(REQ_STORE,         MAX_FRAME_BYTES, 8'h00, 0, 0, 0, 1'b1, ST_STORED, 1, 1, 2);
      add_row(REQ_STORE,         7, 8'h00, 0, 0, 0);
      add_row(REQ_STORE,         100, 8'h00, 0, 0, 0);
      add_row(REQ_STORE,         1000, 8'h00, 0, 0, 0);
      add_row(REQ_STORE,         1500, 8'h00, 0, 0, 0);
      add_row(REQ_STORE,         777, 8'h00, 0, 0, 0);
      add_row(REQ_STORE,         50, 8'h00, 0, 0, 0, 1'b1, ST_FULL, 0, 0, 7);
      add_row(REQ_LOOKUP,        0, 8'h83, 0, 0, 0);
      add_row(REQ_LOOKUP,        0, 8'h07, 0, 0, 0);
      add_row(REQ_LOOKUP,        0, 8'hFF, 0, 0, 0);
      add_row(REQ_BUMP_RETRY,    0, 8'h00, 0, 2, 0, 1'b1, ST_DONE, 0, 0, 7, 1);
      add_row(REQ_BUMP_RETRY,    4095, 8'hFF, 255, 7, 1);
      add_row(REQ_CONSUME,       0, 8'h00, 2, 0, 0, 1'b1, ST_DONE, 0, 0, 5, 0, 2);
      add_row(REQ_CLEAN_THROUGH, 0, 8'h00, 0, 4, 0);
      add_row(REQ_CLEAN_THROUGH, 0, 8'h00, 0, 2, 1);
      add_row(REQ_LOOKUP,        0, 8'h05, 0, 0, 0);
      add_row(REQ_LOOKUP,        0, 8'h03, 0, 0, 0);
      add_row(REQ_RESERVED_A,    0, 8'h00, 0, 0, 0);
      add_row(REQ_RESERVED_B,    4095, 8'hFF, 255, 7, 1);
      add_row(REQ_CONSUME,       0, 8'h00, 255, 0, 0);
      add_row(REQ_CLEAR_ALL,     0, 8'h00, 0, 0, 0, 1'b1, ST_DONE);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i])
         offer_request(opening_rows[i].beat, opening_rows[i].typed, opening_rows[i].want);
      drain_replies();

      // random phases, each setting a minimum length and an idling pattern
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               write_min_len(12'd0);
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               write_min_len(LEN_W'(MAX_FRAME_BYTES));
               send_idle_pct = 67;
               rsp_stall_pct = 0;
            end
            2: begin
               write_min_len(MIN_LEN_RESET);
               send_idle_pct = 0;
               rsp_stall_pct = 67;
               holdoff_asks++;
            end
            3: begin
               write_min_len(LEN_W'(MAX_FRAME_BYTES - 1));
               send_idle_pct = 7;
               rsp_stall_pct = 7;
            end
            4: begin
               write_min_len(12'd1);
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            default: begin
               write_min_len(LEN_W'($urandom_range(0, 40)));
               send_idle_pct = 67;
               rsp_stall_pct = 67;
            end
         endcase

         // long run of bumps on one slot so its retry count wraps
         if (phase == 3) begin
            burst_slot = $urandom_range(0, SLOTS - 1);
            repeat (BUMP_BURST) begin
               r            = next_random_request();
               r.kind       = REQ_BUMP_RETRY;
               r.slot_index = SLOT_W'(burst_slot);
               offer_request(r, 1'b0, none);
            end
         end

         repeat (ITEMS_PER_PHASE) begin
            r = next_random_request();
            offer_request(r, 1'b0, none);
         end
         drain_replies();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_retransmit_window_tracker: clean");
      end else begin
         $display("tb_retransmit_window_tracker: errors");
      end
      $finish;
   end

endmodule
